// ===== hw/rtl/round_robin_process_table_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ROUND_ROBIN_PROCESS_TABLE_MACROS_SVH
`define ROUND_ROBIN_PROCESS_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define RRPT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrpt: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define RRPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrpt: next-cycle check failed");

`endif

// ===== hw/rtl/rrpt_pkg.sv =====
package rrpt_pkg;

    // Sizes fixed by the interface.
    localparam int SLOTS_DEF  = 8;
    localparam int UNIT_W     = 28;
    localparam int PRIO_W     = 3;
    localparam int SLICE_W    = 30;
    localparam int PID_W      = 4;
    localparam int TPID_W     = 4;
    localparam int LIVE_OUT_W = 4;

    localparam logic [UNIT_W-1:0] UNIT_RESET = 28'h010_0000;

    // Slot status codes.
    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_CREATED = 3'd1,
        ST_READY   = 3'd2,
        ST_EXEC    = 3'd3,
        ST_TERM    = 3'd4
    } status_t;

    // Request opcodes.
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_FORK = 2'd1,
        OP_EXIT = 2'd2,
        OP_KILL = 2'd3
    } op_t;

    // Result outcome codes.
    typedef enum logic [1:0] {
        OC_OK      = 2'd0,
        OC_FULL    = 2'd1,
        OC_NORUN   = 2'd2,
        OC_BADKILL = 2'd3
    } outcome_t;

    // One process table entry as stored in the table RAM.
    typedef struct packed {
        status_t             status;
        logic [PRIO_W-1:0]   prio;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     mark;
        logic     scan_init;
        logic     seek;
        logic     kill_rd;
        logic     kill_term;
        logic     set_oc;
        outcome_t oc;
        logic     finish;
    } rrpt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic run_exec;
        logic full;
        logic tpid_bad;
        logic kill_free;
        logic kill_is_run;
        logic seek_hit;
        logic seek_miss;
        logic out_free;
    } rrpt_stat_t;

    function automatic logic is_runnable(status_t s);
        return (s == ST_READY) || (s == ST_CREATED);
    endfunction

    function automatic logic is_free(status_t s);
        return (s == ST_NONE) || (s == ST_TERM);
    endfunction

endpackage

// ===== hw/rtl/rrpt_ram.sv =====
module rrpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rrpt_ctrl.sv =====
module rrpt_ctrl
    import rrpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  rrpt_stat_t st,
    output rrpt_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MARK,
        S_KILL_RD,
        S_KILL_CHK,
        S_SEEK,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.oc     = OC_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (st.op)
                    OP_TICK:
                    begin
                        state_next = S_MARK;
                    end
                    OP_FORK:
                    begin
                        if (st.full)
                        begin
                            cmd.set_oc = 1'b1;
                            cmd.oc     = OC_FULL;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SEEK;
                        end
                    end
                    OP_EXIT:
                    begin
                        if (st.run_exec)
                        begin
                            state_next = S_MARK;
                        end
                        else
                        begin
                            cmd.set_oc = 1'b1;
                            cmd.oc     = OC_NORUN;
                            state_next = S_FINISH;
                        end
                    end
                    OP_KILL:
                    begin
                        if (st.tpid_bad)
                        begin
                            cmd.set_oc = 1'b1;
                            cmd.oc     = OC_BADKILL;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_KILL_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_MARK:
            begin
                // Retire the running slot and start the runnable search.
                cmd.mark      = 1'b1;
                cmd.scan_init = 1'b1;
                state_next    = S_SEEK;
            end
            S_KILL_RD:
            begin
                cmd.kill_rd = 1'b1;
                state_next  = S_KILL_CHK;
            end
            S_KILL_CHK:
            begin
                if (st.kill_free)
                begin
                    cmd.set_oc = 1'b1;
                    cmd.oc     = OC_BADKILL;
                    state_next = S_FINISH;
                end
                else if (st.kill_is_run)
                begin
                    if (st.run_exec)
                    begin
                        state_next = S_MARK;
                    end
                    else
                    begin
                        cmd.set_oc = 1'b1;
                        cmd.oc     = OC_NORUN;
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    cmd.kill_term = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_SEEK:
            begin
                cmd.seek = 1'b1;
                if (st.seek_hit || st.seek_miss)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// ===== hw/rtl/rrpt_datapath.sv =====
module rrpt_datapath
    import rrpt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rrpt_cmd_t             cmd,
    output rrpt_stat_t            st,
    input  logic [1:0]            opcode,
    input  logic [TPID_W-1:0]     target_pid,
    input  logic                  cfg_we,
    input  logic [UNIT_W-1:0]     cfg_wdata,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PID_W-1:0]      running_pid,
    output logic [SLICE_W-1:0]    slice_ticks,
    output logic [PID_W-1:0]      child_pid,
    output logic [1:0]            outcome,
    output logic [LIVE_OUT_W-1:0] live_processes
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int PW = IW + 1;

    // Request and scheduler state.
    op_t                  op_reg;
    logic [TPID_W-1:0]    tpid_reg;
    logic [IW-1:0]        run_reg;
    logic                 run_exec_reg;
    logic [PRIO_W-1:0]    run_prio_reg;
    logic [CW-1:0]        live_reg;
    logic [UNIT_W-1:0]    unit_reg;
    logic [SLOTS-1:0]     valid_reg;

    // Scan and check pipeline.
    logic [IW-1:0]        scan_idx_reg;
    logic [CW-1:0]        scan_cnt_reg;
    logic                 scan_free_reg;
    logic                 chk_pend_reg;
    logic [IW-1:0]        chk_idx_reg;
    logic                 chk_vld_reg;

    // Result staging and output register.
    outcome_t             outcome_reg;
    logic [PID_W-1:0]     child_reg;
    logic                 out_valid_reg;
    logic [PID_W-1:0]     out_run_pid_reg;
    logic [SLICE_W-1:0]   out_slice_reg;
    logic [PID_W-1:0]     out_child_reg;
    outcome_t             out_outcome_reg;
    logic [LIVE_OUT_W-1:0] out_live_reg;

    logic [IW-1:0]        run_plus1;
    logic [IW-1:0]        scan_idx_plus1;
    logic [6:0]           tpid_m1;
    logic [IW-1:0]        tgt_idx;
    logic                 issue;
    logic [IW-1:0]        rd_addr;
    logic [ENTRY_W-1:0]   ram_q;
    entry_t               chk_entry;
    logic                 match;
    logic                 seek_hit;
    logic                 seek_miss;
    logic                 we;
    logic [IW-1:0]        waddr;
    entry_t               wentry;
    logic [PRIO_W-1:0]    fork_prio;
    logic [CW-1:0]        live_drop;
    logic [PW-1:0]        run_pid;
    logic [PW-1:0]        chk_pid;
    logic [PRIO_W+UNIT_W-1:0] slice_prod;

    // Slot index arithmetic, wrapping at SLOTS.
    assign run_plus1      = (run_reg == IW'(SLOTS - 1)) ? '0 : run_reg + 1'b1;
    assign scan_idx_plus1 = (scan_idx_reg == IW'(SLOTS - 1)) ? '0 : scan_idx_reg + 1'b1;
    assign tpid_m1        = 7'(tpid_reg) - 7'd1;
    assign tgt_idx        = tpid_m1[IW-1:0];
    assign run_pid        = PW'(run_reg) + PW'(1);
    assign chk_pid        = PW'(chk_idx_reg) + PW'(1);

    // Table read: one slot per cycle during a scan, or the kill target.
    assign issue   = cmd.seek && (scan_cnt_reg != CW'(SLOTS));
    assign rd_addr = cmd.kill_rd ? tgt_idx : scan_idx_reg;

    // Entries never written read as their reset value.
    always_comb
    begin
        if (chk_vld_reg)
        begin
            chk_entry = entry_t'(ram_q);
        end
        else if (chk_idx_reg == '0)
        begin
            chk_entry = '{status: ST_EXEC, prio: PRIO_W'(1)};
        end
        else
        begin
            chk_entry = '{status: ST_NONE, prio: '0};
        end
    end

    assign match     = scan_free_reg ? is_free(chk_entry.status)
                                     : is_runnable(chk_entry.status);
    assign seek_hit  = chk_pend_reg && match;
    assign seek_miss = !chk_pend_reg && (scan_cnt_reg == CW'(SLOTS));

    assign fork_prio = {1'b0, live_reg[1:0]} + 3'd1;
    assign live_drop = (live_reg == '0) ? '0 : live_reg - 1'b1;

    // Table write port.
    always_comb
    begin
        we     = 1'b0;
        waddr  = run_reg;
        wentry = '{status: ST_NONE, prio: '0};
        if (cmd.mark && ((op_reg != OP_TICK) || run_exec_reg))
        begin
            we     = 1'b1;
            waddr  = run_reg;
            wentry = '{status: (op_reg == OP_TICK) ? ST_READY : ST_TERM,
                       prio: run_prio_reg};
        end
        else if (cmd.kill_term)
        begin
            we     = 1'b1;
            waddr  = chk_idx_reg;
            wentry = '{status: ST_TERM, prio: chk_entry.prio};
        end
        else if (cmd.seek && seek_hit)
        begin
            we    = 1'b1;
            waddr = chk_idx_reg;
            if (scan_free_reg)
            begin
                wentry = '{status: ST_CREATED, prio: fork_prio};
            end
            else
            begin
                wentry = '{status: ST_EXEC, prio: chk_entry.prio};
            end
        end
    end

    rrpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wentry),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // Scheduler state, scan control and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= '0;
            run_exec_reg  <= 1'b1;
            run_prio_reg  <= PRIO_W'(1);
            live_reg      <= CW'(1);
            unit_reg      <= UNIT_RESET;
            valid_reg     <= '0;
            scan_idx_reg  <= '0;
            scan_cnt_reg  <= '0;
            scan_free_reg <= 1'b0;
            chk_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unit_reg <= cfg_wdata;
            end
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (cmd.mark)
            begin
                run_exec_reg <= 1'b0;
                if (op_reg != OP_TICK)
                begin
                    live_reg <= live_drop;
                end
            end
            if (cmd.kill_term)
            begin
                live_reg <= live_drop;
            end
            if (cmd.seek && seek_hit)
            begin
                if (scan_free_reg)
                begin
                    live_reg <= live_reg + 1'b1;
                end
                else
                begin
                    run_reg      <= chk_idx_reg;
                    run_exec_reg <= 1'b1;
                    run_prio_reg <= chk_entry.prio;
                end
            end
            chk_pend_reg <= issue;
            if (cmd.scan_init)
            begin
                scan_idx_reg  <= run_plus1;
                scan_cnt_reg  <= '0;
                scan_free_reg <= (op_reg == OP_FORK);
            end
            else if (issue)
            begin
                scan_idx_reg <= scan_idx_plus1;
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign slice_prod = run_prio_reg * unit_reg;

    // Request capture, result staging and output payload.
    always_ff @(posedge clk)
    begin
        chk_idx_reg <= rd_addr;
        chk_vld_reg <= valid_reg[rd_addr];
        if (cmd.load)
        begin
            op_reg      <= op_t'(opcode);
            tpid_reg    <= target_pid;
            outcome_reg <= OC_OK;
            child_reg   <= '0;
        end
        if (cmd.set_oc)
        begin
            outcome_reg <= cmd.oc;
        end
        if (cmd.seek && seek_miss)
        begin
            outcome_reg <= scan_free_reg ? OC_FULL : OC_NORUN;
        end
        if (cmd.seek && seek_hit && scan_free_reg)
        begin
            child_reg <= PID_W'(chk_pid);
        end
        if (cmd.finish)
        begin
            out_run_pid_reg <= PID_W'(run_pid);
            out_slice_reg   <= run_exec_reg ? slice_prod[SLICE_W-1:0] : '0;
            out_child_reg   <= child_reg;
            out_outcome_reg <= outcome_reg;
            out_live_reg    <= LIVE_OUT_W'(live_reg);
        end
    end

    // Status to the controller.
    assign st.op          = op_reg;
    assign st.run_exec    = run_exec_reg;
    assign st.full        = (live_reg >= CW'(SLOTS));
    assign st.tpid_bad    = (tpid_reg == '0) || (7'(tpid_reg) > 7'(SLOTS));
    assign st.kill_free   = is_free(chk_entry.status);
    assign st.kill_is_run = (tgt_idx == run_reg);
    assign st.seek_hit    = seek_hit;
    assign st.seek_miss   = seek_miss;
    assign st.out_free    = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign running_pid    = out_run_pid_reg;
    assign slice_ticks    = out_slice_reg;
    assign child_pid      = out_child_reg;
    assign outcome        = out_outcome_reg;
    assign live_processes = out_live_reg;

endmodule

// ===== hw/rtl/round_robin_process_table.sv =====
// Round-robin process table with SLOTS entries.
// Requests arrive on in_valid/in_ready with opcode (tick, fork, exit, kill)
// and target_pid; each request produces exactly one result on
// out_valid/out_ready carrying running_pid, slice_ticks, child_pid,
// outcome and live_processes. cfg_we/cfg_wdata set slice_unit_ticks; the
// user must write them only while idle, as the block does not enforce it.
// A fork on a full table, an exit while idle and a kill of pid 0 or above
// SLOTS finish without touching the table; any other kill of a process that
// is not running reads its target slot and finishes. A tick, an exit and a
// kill of the executing process update the running slot and then scan for
// the next runnable slot, and a fork scans for a free slot; a scan starts at
// the slot after the running one and can cover all SLOTS slots. The table
// RAM is read one slot per cycle during a scan. in_ready rises with out_valid.
// One request is processed at a time. A finished result waits in the output
// register; if the receiver stalls with a result pending, the next result
// holds until the register is free, and new requests are held off meanwhile.
// Reset puts slot 0 in the executing state with priority 1, all other slots
// unused, the live count at one and slice_unit_ticks at 0x100000; requests
// are accepted right after reset.
module round_robin_process_table
    import rrpt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [UNIT_W-1:0]     cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            opcode,
    input  logic [TPID_W-1:0]     target_pid,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PID_W-1:0]      running_pid,
    output logic [SLICE_W-1:0]    slice_ticks,
    output logic [PID_W-1:0]      child_pid,
    output logic [1:0]            outcome,
    output logic [LIVE_OUT_W-1:0] live_processes
);

    rrpt_cmd_t  cmd;
    rrpt_stat_t st;

    // Sequencing of each request.
    rrpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Table, scheduler registers and result register.
    rrpt_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .opcode         (opcode),
        .target_pid     (target_pid),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .running_pid    (running_pid),
        .slice_ticks    (slice_ticks),
        .child_pid      (child_pid),
        .outcome        (outcome),
        .live_processes (live_processes)
    );

endmodule

// ===== hw/rtl/rrpt_checker.sv =====
`include "round_robin_process_table_macros.svh"

module rrpt_checker
    import rrpt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [PID_W-1:0]      running_pid,
    input logic [SLICE_W-1:0]    slice_ticks,
    input logic [PID_W-1:0]      child_pid,
    input logic [1:0]            outcome,
    input logic [LIVE_OUT_W-1:0] live_processes
);

    // A stalled result stays valid and keeps its pid, child, outcome and live count.
    `RRPT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(running_pid))
    `RRPT_ASSERT_NEXT(a_out_data, out_valid && !out_ready, $stable({child_pid, outcome, live_processes}))

    // Requests are handled one at a time: ready drops after each acceptance.
    `RRPT_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

    // A child pid is only reported by a successful fork.
    `RRPT_ASSERT_NOW(a_child_ok, out_valid && (child_pid != '0), outcome == OC_OK)

    // With nothing runnable the timer reload is zero.
    `RRPT_ASSERT_NOW(a_idle_slice, out_valid && (outcome == OC_NORUN), slice_ticks == '0)

endmodule

bind round_robin_process_table rrpt_checker #(.SLOTS(SLOTS)) u_rrpt_checker (.*);
